/* design/assert_macros.svh */
// Assertion helpers, included by halton_point_generator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, off while reset is asserted.
`define HPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Implication form with the same clocking and reset handling.
`define HPG_ASSERT_IMP(lbl, pre, post, msg) \
  `HPG_ASSERT(lbl, (pre) |-> (post), msg)

`endif

/* design/hpg_pkg.sv */
package hpg_pkg;

  localparam int unsigned MAX_DIMS_DEF  = 16;
  localparam int unsigned FRAC_BITS_DEF = 32;
  localparam int unsigned PRIME_COUNT   = 59;

  localparam int unsigned IDX_W   = 32;  // sequence index width
  localparam int unsigned BASE_W  = 9;   // largest base is 281
  localparam int unsigned DEN_W   = IDX_W + BASE_W;  // base^digits stays below this
  localparam int unsigned REM_W   = DEN_W + 1;       // remainder after the shift
  localparam int unsigned CHUNK_W = 24;  // multiplier operand slice
  localparam int unsigned DIM_W   = 4;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned CFG_W   = 5;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_GEN  = 1'b1;

  // Odd primes in dimension order.
  function automatic logic [BASE_W-1:0] prime_at(input logic [5:0] idx);
    logic [BASE_W-1:0] p;
    case (idx)
      6'd0:  p = 9'd3;    6'd1:  p = 9'd5;    6'd2:  p = 9'd7;    6'd3:  p = 9'd11;
      6'd4:  p = 9'd13;   6'd5:  p = 9'd17;   6'd6:  p = 9'd19;   6'd7:  p = 9'd23;
      6'd8:  p = 9'd29;   6'd9:  p = 9'd31;   6'd10: p = 9'd37;   6'd11: p = 9'd41;
      6'd12: p = 9'd43;   6'd13: p = 9'd47;   6'd14: p = 9'd53;   6'd15: p = 9'd59;
      6'd16: p = 9'd61;   6'd17: p = 9'd67;   6'd18: p = 9'd71;   6'd19: p = 9'd73;
      6'd20: p = 9'd79;   6'd21: p = 9'd83;   6'd22: p = 9'd89;   6'd23: p = 9'd97;
      6'd24: p = 9'd101;  6'd25: p = 9'd103;  6'd26: p = 9'd107;  6'd27: p = 9'd109;
      6'd28: p = 9'd113;  6'd29: p = 9'd127;  6'd30: p = 9'd131;  6'd31: p = 9'd137;
      6'd32: p = 9'd139;  6'd33: p = 9'd149;  6'd34: p = 9'd151;  6'd35: p = 9'd157;
      6'd36: p = 9'd163;  6'd37: p = 9'd167;  6'd38: p = 9'd173;  6'd39: p = 9'd179;
      6'd40: p = 9'd181;  6'd41: p = 9'd191;  6'd42: p = 9'd193;  6'd43: p = 9'd197;
      6'd44: p = 9'd199;  6'd45: p = 9'd211;  6'd46: p = 9'd223;  6'd47: p = 9'd227;
      6'd48: p = 9'd229;  6'd49: p = 9'd233;  6'd50: p = 9'd239;  6'd51: p = 9'd241;
      6'd52: p = 9'd251;  6'd53: p = 9'd257;  6'd54: p = 9'd263;  6'd55: p = 9'd269;
      6'd56: p = 9'd271;  6'd57: p = 9'd277;  6'd58: p = 9'd281;
      default: p = 9'd3;
    endcase
    return p;
  endfunction

endpackage

/* design/halton_point_generator.sv */
// Halton point generator. A load word (op 0) stores the lower and upper bound of one
// dimension and finishes at once; a generate word (op 1) emits one coordinate word per
// dimension in use, in dimension order, with last_o on the final one. busy_o is high
// from the cycle after a generate word is taken and is low again when the last coordinate
// is strobed; start_i is ignored while busy_o is high. Each coordinate is shown on the
// result ports for exactly one cycle with valid_o high; the receiver cannot stall it, so
// it must take every strobed word. A fixed dimension (equal bounds) goes through S_RD_WAIT,
// S_DIM and S_EMIT. A free dimension in base b also runs through the base-b digits of the
// running index: one shared compare-subtract unit first peels off each digit by a 32-step
// division and then forms the fraction one bit per cycle, and one 32x24 multiplier scales
// it one 24-bit slice at a time. dimension_count is written through cfg_we_i/cfg_wdata_i
// and must only change while busy_o is low.
module halton_point_generator #(
  parameter int unsigned MAX_DIMS  = hpg_pkg::MAX_DIMS_DEF,
  parameter int unsigned FRAC_BITS = hpg_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        op_i,
  input  logic [hpg_pkg::DIM_W-1:0]   dim_index_i,
  input  logic signed [31:0]          lower_bound_i,
  input  logic signed [31:0]          upper_bound_i,
  input  logic                        cfg_we_i,
  input  logic [hpg_pkg::CFG_W-1:0]   cfg_wdata_i,
  output logic                        valid_o,
  output logic [hpg_pkg::DIM_W-1:0]   out_dim_o,
  output logic signed [31:0]          coordinate_o,
  output logic                        last_o
);

  `include "assert_macros.svh"

  localparam int unsigned AW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int unsigned CW    = $clog2(MAX_DIMS + 1);
  localparam int unsigned MAXST = (FRAC_BITS > hpg_pkg::IDX_W) ? FRAC_BITS : hpg_pkg::IDX_W;
  localparam int unsigned SW    = $clog2(MAXST);
  localparam int unsigned NCH   = (FRAC_BITS + hpg_pkg::CHUNK_W - 1) / hpg_pkg::CHUNK_W;
  localparam int unsigned UPW   = NCH * hpg_pkg::CHUNK_W;
  localparam int unsigned PAD   = UPW - FRAC_BITS;
  localparam int unsigned ACC_W = hpg_pkg::COORD_W + UPW;
  localparam int unsigned KW    = (NCH > 1) ? $clog2(NCH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RD_WAIT, S_DIM, S_DIV, S_ACC, S_FRAC, S_MUL, S_EMIT
  } state_e;

  state_e                     state_q;
  logic [hpg_pkg::CFG_W-1:0]  dim_count_q;
  logic [CW-1:0]              count_q, d_q;
  logic [MAX_DIMS-1:0]        free_q;
  logic [31:0]                seq_q;
  logic [31:0]                n_q;
  logic [hpg_pkg::REM_W-1:0]  rem_q;
  logic [SW-1:0]              step_q;
  logic [KW-1:0]              k_q;
  logic [hpg_pkg::DEN_W-1:0]  num_q, den_q;
  logic [hpg_pkg::BASE_W-1:0] base_q;
  logic [FRAC_BITS-1:0]       u_q;
  logic [UPW-1:0]             upad_q;
  logic [ACC_W-1:0]           acc_q;
  logic [31:0]                lo_q, mag_q;
  logic                       neg_q, is_free_q;

  // Bound table: lower bound in the low half, upper in the high half.
  logic        ram_we;
  logic [63:0] ram_rdata;

  assign ram_we = (state_q == S_IDLE) && start_i && (op_i == hpg_pkg::OP_LOAD) &&
                  (32'(dim_index_i) < 32'(MAX_DIMS));

  hpg_ram #(.WIDTH(64), .DEPTH(MAX_DIMS)) u_bounds (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(dim_index_i)),
    .wdata_i ({upper_bound_i, lower_bound_i}),
    .raddr_i (AW'(d_q)),
    .rdata_o (ram_rdata)
  );

  // The shared compare-subtract unit: digit extraction in S_DIV, fraction bits in S_FRAC.
  logic                      ds_bit, ds_q;
  logic [hpg_pkg::DEN_W-1:0] ds_div;
  logic [hpg_pkg::REM_W-1:0] ds_rem;

  assign ds_bit = (state_q == S_DIV) ? n_q[31] : 1'b0;
  assign ds_div = (state_q == S_DIV) ? hpg_pkg::DEN_W'(base_q) : den_q;

  hpg_divstep u_divstep (
    .rem_i     (rem_q),
    .bit_i     (ds_bit),
    .divisor_i (ds_div),
    .rem_o     (ds_rem),
    .q_o       (ds_q)
  );

  // Datapath helpers.
  logic [32:0]               diff;
  logic [32:0]               diff_abs;
  logic [hpg_pkg::DEN_W-1:0] num_next, den_next;
  logic [hpg_pkg::CHUNK_W-1:0] chunk;
  logic [ACC_W-1:0]          prod;
  logic [31:0]               term, coord;
  logic                      last_now;
  logic [CW-1:0]             count_sat;

  always_comb begin
    diff     = {ram_rdata[63], ram_rdata[63:32]} - {ram_rdata[31], ram_rdata[31:0]};
    diff_abs = diff[32] ? (33'd0 - diff) : diff;
    num_next = hpg_pkg::DEN_W'(num_q * base_q) + hpg_pkg::DEN_W'(rem_q);
    den_next = hpg_pkg::DEN_W'(den_q * base_q);
    chunk    = upad_q[UPW-1 -: hpg_pkg::CHUNK_W];
    prod     = ACC_W'(mag_q) * ACC_W'(chunk);
    term     = acc_q[ACC_W-1 -: 32];
    coord    = !is_free_q ? lo_q : (neg_q ? (lo_q - term) : (lo_q + term));
    last_now = (CW'(d_q + 1'b1) == count_q);
    count_sat = (32'(dim_count_q) > 32'(MAX_DIMS)) ? CW'(MAX_DIMS) : CW'(dim_count_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      dim_count_q  <= '0;
      count_q      <= '0;
      d_q          <= '0;
      free_q       <= '0;
      seq_q        <= '0;
      n_q          <= '0;
      rem_q        <= '0;
      step_q       <= '0;
      k_q          <= '0;
      num_q        <= '0;
      den_q        <= '0;
      base_q       <= '0;
      u_q          <= '0;
      upad_q       <= '0;
      acc_q        <= '0;
      lo_q         <= '0;
      mag_q        <= '0;
      neg_q        <= 1'b0;
      is_free_q    <= 1'b0;
      valid_o      <= 1'b0;
      out_dim_o    <= '0;
      coordinate_o <= '0;
      last_o       <= 1'b0;
    end else begin
      valid_o <= 1'b0;
      if (cfg_we_i) begin
        dim_count_q <= cfg_wdata_i;
      end
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            if (op_i == hpg_pkg::OP_LOAD) begin
              if (ram_we) begin
                free_q[AW'(dim_index_i)] <= (lower_bound_i != upper_bound_i);
              end
            end else if (count_sat != '0) begin
              count_q <= count_sat;
              d_q     <= '0;
              state_q <= S_RD_WAIT;
            end
          end
        end
        S_RD_WAIT: begin
          state_q <= S_DIM;
        end
        S_DIM: begin
          lo_q      <= ram_rdata[31:0];
          neg_q     <= diff[32];
          mag_q     <= diff_abs[31:0];
          is_free_q <= free_q[AW'(d_q)];
          base_q    <= hpg_pkg::prime_at(6'(d_q));
          n_q       <= seq_q;
          num_q     <= '0;
          den_q     <= hpg_pkg::DEN_W'(1);
          rem_q     <= '0;
          step_q    <= '0;
          u_q       <= '0;
          if (!free_q[AW'(d_q)]) begin
            state_q <= S_EMIT;
          end else if (seq_q == '0) begin
            state_q <= S_FRAC;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          n_q    <= {n_q[30:0], ds_q};
          rem_q  <= ds_rem;
          step_q <= step_q + 1'b1;
          if (step_q == SW'(31)) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          num_q  <= num_next;
          den_q  <= den_next;
          step_q <= '0;
          if (n_q == '0) begin
            rem_q   <= hpg_pkg::REM_W'(num_next);
            state_q <= S_FRAC;
          end else begin
            rem_q   <= '0;
            state_q <= S_DIV;
          end
        end
        S_FRAC: begin
          u_q    <= {u_q[FRAC_BITS-2:0], ds_q};
          rem_q  <= ds_rem;
          step_q <= step_q + 1'b1;
          if (step_q == SW'(FRAC_BITS - 1)) begin
            upad_q  <= UPW'({u_q[FRAC_BITS-2:0], ds_q}) << PAD;
            acc_q   <= '0;
            k_q     <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          // Most significant slice first, so the accumulator only ever shifts by a fixed amount.
          acc_q  <= (acc_q << hpg_pkg::CHUNK_W) + prod;
          upad_q <= upad_q << hpg_pkg::CHUNK_W;
          k_q    <= k_q + 1'b1;
          if (k_q == KW'(NCH - 1)) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          valid_o      <= 1'b1;
          out_dim_o    <= hpg_pkg::DIM_W'(d_q);
          coordinate_o <= coord;
          last_o       <= last_now;
          if (is_free_q) begin
            seq_q <= seq_q + 32'd1;
          end
          d_q     <= CW'(d_q + 1'b1);
          state_q <= last_now ? S_IDLE : S_RD_WAIT;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);

  // A point's final word closes the burst: nothing can follow in the next cycle.
  `HPG_ASSERT_IMP(a_last_ends_burst, valid_o && last_o, ##1 !valid_o, "word after last")
  // Every strobed word comes out of a generate that was in progress.
  `HPG_ASSERT_IMP(a_strobe_from_busy, valid_o, $past(busy_o), "strobe while idle")
  // Until the last word of a point is out, the block stays busy.
  `HPG_ASSERT_IMP(a_mid_point_busy, valid_o && !last_o, busy_o, "idle inside a point")

endmodule

/* design/hpg_ram.sv */
module hpg_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

/* design/hpg_divstep.sv */
// One restoring division step: shift in a bit, subtract the divisor if it fits.
module hpg_divstep (
  input  logic [hpg_pkg::REM_W-1:0] rem_i,
  input  logic                      bit_i,
  input  logic [hpg_pkg::DEN_W-1:0] divisor_i,
  output logic [hpg_pkg::REM_W-1:0] rem_o,
  output logic                      q_o
);

  logic [hpg_pkg::REM_W-1:0] shifted;

  always_comb begin
    shifted = {rem_i[hpg_pkg::REM_W-2:0], bit_i};
    q_o     = (shifted >= hpg_pkg::REM_W'(divisor_i));
    rem_o   = q_o ? (shifted - hpg_pkg::REM_W'(divisor_i)) : shifted;
  end

endmodule

/* verif/halton_point_generator_tb.sv */
module halton_point_generator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // A coordinate word as it should appear on the result ports.
  typedef struct packed {
    logic [hpg_pkg::DIM_W-1:0]   dim;
    logic [hpg_pkg::COORD_W-1:0] coord;
    logic                        last;
  } coord_word_t;

  localparam int unsigned DIMS        = hpg_pkg::MAX_DIMS_DEF;
  localparam int unsigned CYCLE_LIMIT = 20_000_000;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic                        op_i;
  logic [hpg_pkg::DIM_W-1:0]   dim_index_i;
  logic signed [31:0]          lower_bound_i;
  logic signed [31:0]          upper_bound_i;
  logic                        cfg_we_i;
  logic [hpg_pkg::CFG_W-1:0]   cfg_wdata_i;
  logic                        valid_o;
  logic [hpg_pkg::DIM_W-1:0]   out_dim_o;
  logic signed [31:0]          coordinate_o;
  logic                        last_o;

  halton_point_generator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .op_i          (op_i),
    .dim_index_i   (dim_index_i),
    .lower_bound_i (lower_bound_i),
    .upper_bound_i (upper_bound_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .valid_o       (valid_o),
    .out_dim_o     (out_dim_o),
    .coordinate_o  (coordinate_o),
    .last_o        (last_o)
  );

  // Shadow copy of the block's state, kept in step with every accepted word.
  logic [31:0]               lower_shadow [DIMS];
  logic [31:0]               upper_shadow [DIMS];
  logic                      free_shadow  [DIMS];
  logic [31:0]               seq_index;
  logic [hpg_pkg::CFG_W-1:0] dim_count;

  // Coordinates that the block still owes us, oldest first.
  coord_word_t pending_coords[$];

  // The odd prime used as the base of each dimension.
  int unsigned dim_base [DIMS] = '{3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59};

  int unsigned error_count;
  int unsigned words_sent;
  int unsigned gen_words;
  int unsigned coords_seen;
  int unsigned cycle_count;
  bit          sender_steady;  // when set, the sender never idles

  // 100 MHz clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // A hard ceiling on the run, far above the slowest legal run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    error_count++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  // Radical inverse of n in base b as an unsigned fraction with 32 bits,
  // truncated toward zero. The digits of n are mirrored about the point and
  // the resulting ratio is expanded one bit at a time.
  function automatic logic [31:0] radical_fraction(input logic [31:0] n,
                                                   input int unsigned b);
    logic [63:0] mirrored;
    logic [63:0] denom;
    logic [64:0] remainder;
    logic [31:0] frac;
    logic [31:0] rest;
    mirrored = 0;
    denom    = 1;
    frac     = 0;
    rest     = n;
    while (rest != 0) begin
      mirrored = mirrored * b + (rest % b);
      denom    = denom * b;
      rest     = rest / b;
    end
    remainder = {1'b0, mirrored};
    for (int i = 0; i < 32; i++) begin
      remainder = remainder << 1;
      frac      = frac << 1;
      if (remainder >= {1'b0, denom}) begin
        remainder = remainder - {1'b0, denom};
        frac[0]   = 1'b1;
      end
    end
    return frac;
  endfunction

  // One coordinate of a free dimension: lower + u*(upper-lower), with u in Q0.32
  // and the product truncated toward zero to a whole integer step.
  function automatic logic [31:0] scaled_coord(input logic [31:0] lo,
                                               input logic [31:0] up,
                                               input logic [31:0] u);
    logic signed [33:0] span;
    logic [33:0]        span_mag;
    logic [127:0]       prod;
    logic [31:0]        step;
    span     = $signed({{2{up[31]}}, up}) - $signed({{2{lo[31]}}, lo});
    span_mag = span[33] ? -span : span;
    prod     = 128'(span_mag) * 128'(u);
    step     = prod[63:32];
    return span[33] ? lo - step : lo + step;
  endfunction

  // Applies one accepted word to the shadow state and queues the coordinates
  // it is due to produce.
  task automatic predict_word(input logic op, input logic [hpg_pkg::DIM_W-1:0] dim,
                              input logic [31:0] lo, input logic [31:0] up);
    int unsigned n_dims;
    coord_word_t w;
    if (op == hpg_pkg::OP_LOAD) begin
      lower_shadow[dim] = lo;
      upper_shadow[dim] = up;
      free_shadow[dim]  = (lo != up);
    end else begin
      n_dims = (dim_count > DIMS) ? DIMS : dim_count;
      gen_words++;
      for (int unsigned d = 0; d < n_dims; d++) begin
        w.dim   = hpg_pkg::DIM_W'(d);
        w.last  = (d + 1 == n_dims);
        w.coord = lower_shadow[d];
        if (free_shadow[d]) begin
          w.coord = scaled_coord(lower_shadow[d], upper_shadow[d],
                                 radical_fraction(seq_index, dim_base[d]));
          seq_index = seq_index + 1;
        end
        pending_coords = {pending_coords, w};
      end
    end
  endtask

  // Result checker. Outputs are sampled mid-cycle, well away from the edge
  // at which they change, and each strobed word is held against the oldest
  // coordinate still owed.
  always @(negedge clk_i) begin
    coord_word_t want;
    if (rst_ni && valid_o) begin
      coords_seen++;
      if (pending_coords.size() == 0) begin
        report_mismatch($sformatf("unexpected word dim %0d coord %h last %b",
                                  out_dim_o, coordinate_o, last_o));
      end else begin
        want = pending_coords.pop_front();
        if (out_dim_o !== want.dim)
          report_mismatch($sformatf("out_dim %0d, want %0d", out_dim_o, want.dim));
        if (coordinate_o !== want.coord)
          report_mismatch($sformatf("coordinate %h, want %h (dim %0d)",
                                    coordinate_o, want.coord, want.dim));
        if (last_o !== want.last)
          report_mismatch($sformatf("last %b, want %b (dim %0d)",
                                    last_o, want.last, want.dim));
      end
    end
  end

  // Presents one word and holds it until the block takes it. busy_o only
  // moves at a rising edge, so its value at the falling edge is the one the
  // next rising edge sees. Called and returns at a rising edge; start_i is
  // left high so that a following word can go out back to back.
  task automatic send_word(input logic op, input logic [hpg_pkg::DIM_W-1:0] dim,
                           input logic [31:0] lo, input logic [31:0] up);
    bit taken;
    start_i       <= 1'b1;
    op_i          <= op;
    dim_index_i   <= dim;
    lower_bound_i <= lo;
    upper_bound_i <= up;
    taken = 0;
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy_o;
      @(posedge clk_i);
    end
    predict_word(op, dim, lo, up);
    words_sent++;
  endtask

  // Random sender idling: roughly 31 calls in a hundred insert an idle gap.
  task automatic sender_gap();
    int unsigned n;
    if (!sender_steady && $urandom_range(99) < 31) begin
      n = $urandom_range(6, 1);
      start_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Holds off until every owed coordinate has arrived and the block is idle.
  // Load words leave nothing owed, so the task then also waits for busy_o to fall.
  task automatic wait_idle();
    start_i <= 1'b0;
    while (pending_coords.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_dim_count(input logic [hpg_pkg::CFG_W-1:0] value);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    dim_count = value;
  endtask

  // A random load word: fixed, narrow, or fully random bounds.
  task automatic send_random_load(input logic [hpg_pkg::DIM_W-1:0] dim);
    logic [31:0] lo;
    logic [31:0] up;
    lo = $urandom();
    case ($urandom_range(3))
      0: up = lo;
      1: up = $urandom();
      default: up = lo + $urandom_range(32'h0004_0000) - 32'h0002_0000;
    endcase
    send_word(hpg_pkg::OP_LOAD, dim, lo, up);
  endtask

  // A generate word carries don't-care fields; they are still randomized.
  task automatic send_generate();
    send_word(hpg_pkg::OP_GEN, hpg_pkg::DIM_W'($urandom()), $urandom(), $urandom());
  endtask

  // Before any dimension is set up, a zero count yields no coordinate.
  task automatic test_zero_count();
    send_generate();
    sender_gap();
    send_generate();
  endtask

  // Bound extremes: full positive and negative spans, reversed bounds, a
  // fixed dimension, and every table entry written so no later point can
  // touch an unwritten one. The first free dimension sees index zero.
  task automatic test_bound_extremes();
    send_word(hpg_pkg::OP_LOAD, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    send_word(hpg_pkg::OP_LOAD, 4'd1, 32'h7FFF_FFFF, 32'h8000_0000);
    send_word(hpg_pkg::OP_LOAD, 4'd2, 32'h0001_0000, 32'h0001_0000);
    send_word(hpg_pkg::OP_LOAD, 4'd3, 32'hFFFF_FFFF, 32'h0000_0000);
    for (int d = 4; d < DIMS; d++) send_random_load(hpg_pkg::DIM_W'(d));
    write_dim_count(5'd1);
    send_generate();
    send_generate();
    write_dim_count(5'd4);
    send_generate();
    send_generate();
  endtask

  // Counts of exactly the table size and above it, which saturates.
  task automatic test_count_limits();
    write_dim_count(5'd16);
    send_generate();
    write_dim_count(5'd31);
    send_generate();
    write_dim_count(5'd17);
    send_generate();
  endtask

  // Random phases: each picks a count (mostly small, since a free dimension
  // is slow to generate), then mixes reloads with generate words. One phase
  // runs without sender idling, and one drains fully midway.
  task automatic test_random_points();
    logic [hpg_pkg::CFG_W-1:0] cnt;
    for (int phase = 0; phase < 14; phase++) begin
      case (phase)
        0:       cnt = 5'd0;
        5:       cnt = 5'd16;
        default: cnt = ($urandom_range(9) == 0) ? hpg_pkg::CFG_W'($urandom())
                                                : hpg_pkg::CFG_W'($urandom_range(5, 1));
      endcase
      write_dim_count(cnt);
      sender_steady = (phase == 3);
      for (int i = 0; i < 20; i++) begin
        if ($urandom_range(99) < 40) send_random_load(hpg_pkg::DIM_W'($urandom()));
        else send_generate();
        if (phase == 7 && i == 10) wait_idle();
        sender_gap();
      end
    end
    sender_steady = 0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    op_i          = hpg_pkg::OP_LOAD;
    dim_index_i   = '0;
    lower_bound_i = '0;
    upper_bound_i = '0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    cycle_count   = 0;
    error_count   = 0;
    words_sent    = 0;
    gen_words     = 0;
    coords_seen   = 0;
    sender_steady = 0;
    seq_index     = '0;
    dim_count     = '0;
    for (int d = 0; d < DIMS; d++) begin
      lower_shadow[d] = '0;
      upper_shadow[d] = '0;
      free_shadow[d]  = 1'b0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_count();
    test_bound_extremes();
    test_count_limits();
    test_random_points();

    // Drain, then wait on for any stray word.
    wait_idle();
    repeat (50) @(posedge clk_i);

    $display("Sent %0d words (%0d generate), checked %0d coordinates.",
             words_sent, gen_words, coords_seen);
    $display("Counts 0 to 31 with saturation, fixed, reversed and extreme bounds covered.");
    if (error_count == 0 && pending_coords.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d coordinates missing", error_count,
               pending_coords.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
